>>> rtl/core/ut_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ut_pkg;

  // Line and token limits
  localparam int MAX_LINE_BYTES = 4096;
  localparam int MAX_TOKENS     = 256;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int NUM_W   = 8;
  localparam int CP_W    = 21;
  localparam int POS_W   = $clog2(MAX_LINE_BYTES + 1);
  localparam int CNT_W   = $clog2(MAX_TOKENS + 1);

  // Event queue between decoder and token tracker
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UTF8   = 2'd1,
    ST_TOKENS = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  // What one decoded byte means to the token tracker
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_SPACE = 3'd1,
    EV_WORD  = 3'd2,
    EV_UTF8  = 3'd3,
    EV_LONG  = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t             kind;
    logic                 last;
    logic [START_W-1:0]   char_start;
    logic [POS_W-1:0]     byte_end;
  } ev_t;

  // Unicode White_Space property over a code point
  function automatic logic is_space(input logic [CP_W-1:0] c);
    is_space = (c >= 21'h9 && c <= 21'hd) || c == 21'h20 || c == 21'h85
            || c == 21'ha0 || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200a)
            || c == 21'h2028 || c == 21'h2029 || c == 21'h202f
            || c == 21'h205f || c == 21'h3000;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ut_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte stream of one line
interface ut_byte_if;
  logic                     valid;
  logic                     ready;
  logic [ut_pkg::BYTE_W-1:0] byte_req;
  logic                     last_byte;

  modport source(output valid, output byte_req, output last_byte, input ready);
  modport sink(input valid, input byte_req, input last_byte, output ready);
endinterface

// Token / status results
interface ut_tok_if;
  logic                      valid;
  logic                      ready;
  logic                      has_token;
  logic [ut_pkg::START_W-1:0] token_start;
  logic [ut_pkg::LEN_W-1:0]   token_length;
  logic [ut_pkg::NUM_W-1:0]   token_number;
  logic [1:0]                status;
  logic                      end_of_line;

  modport source(output valid, output has_token, output token_start, output token_length,
                 output token_number, output status, output end_of_line, input ready);
  modport sink(input valid, input has_token, input token_start, input token_length,
               input token_number, input status, input end_of_line, output ready);
endinterface

`default_nettype wire

>>> rtl/core/unicode_whitespace_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Payload                                                   Accept
// byte_ch    in   byte_req[7:0], last_byte                                   valid && ready
// token_ch   out  has_token, token_start[11:0], token_length[12:0],          valid && ready
//                 token_number[7:0], status[1:0], end_of_line
//
// One byte per cycle sustained while token_ch does not stall; a byte's result
// passes the event queue (written at the accepting edge), then the result register.
// The decoder and token tracker are split by a two-entry event queue, so a stall
// on token_ch backs up into the queue before byte_ch drops ready.
// rst is synchronous and clears all line state; each line clears itself after
// its final byte.
module unicode_whitespace_tokenizer (
  input  wire logic clk,
  input  wire logic rst,
  ut_byte_if.sink   byte_ch,
  ut_tok_if.source  token_ch
);

  ut_pkg::ev_t front_ev, back_ev;
  logic        front_valid, front_ready;
  logic        back_valid, back_ready;

  ut_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .ev       (front_ev),
    .ev_valid (front_valid),
    .ev_ready (front_ready)
  );

  ut_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_ev    (front_ev),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_ev     (back_ev),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  ut_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev       (back_ev),
    .ev_valid (back_valid),
    .ev_ready (back_ready),
    .token_ch (token_ch)
  );

endmodule

`default_nettype wire

>>> rtl/core/ut_front.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 decoder and classifier: one event per accepted byte
module ut_front (
  input  wire logic   clk,
  input  wire logic   rst,
  ut_byte_if.sink     byte_ch,
  output ut_pkg::ev_t ev,
  output logic        ev_valid,
  input  wire logic   ev_ready
);

  localparam logic [ut_pkg::CP_W-1:0] MIN2 = 21'h80;
  localparam logic [ut_pkg::CP_W-1:0] MIN3 = 21'h800;
  localparam logic [ut_pkg::CP_W-1:0] MIN4 = 21'h10000;

  logic [1:0]                pend, pend_next;
  logic [1:0]                seql, seql_next;
  logic [ut_pkg::CP_W-1:0]    cp, cp_next;
  logic [ut_pkg::POS_W-1:0]   pos, pos_next;
  logic [ut_pkg::START_W-1:0] cs, cs_next;
  logic [ut_pkg::CP_W-1:0]    minimum;
  ut_pkg::ev_kind_t          kind;
  logic [ut_pkg::BYTE_W-1:0]  b;
  logic                      acc;

  assign b             = byte_ch.byte_req;
  assign byte_ch.ready = ev_ready;
  assign ev_valid      = byte_ch.valid;
  assign acc           = byte_ch.valid && ev_ready;

  // Sequence minimum for overlong check
  always_comb begin
    unique case (seql)
      2'd1:    minimum = MIN2;
      2'd2:    minimum = MIN3;
      default: minimum = MIN4;
    endcase
  end

  // Decode one byte
  always_comb begin
    pend_next = pend;
    seql_next = seql;
    cp_next   = cp;
    pos_next  = pos;
    cs_next   = cs;
    kind      = ut_pkg::EV_NONE;
    if (pos >= ut_pkg::POS_W'(ut_pkg::MAX_LINE_BYTES)) begin
      kind = ut_pkg::EV_LONG;
    end else begin
      pos_next = pos + 1'b1;
      if (pend == 2'd0) begin
        cs_next = pos[ut_pkg::START_W-1:0];
        if (!b[7]) begin
          cp_next = {13'd0, b};
          kind    = ut_pkg::is_space(cp_next) ? ut_pkg::EV_SPACE : ut_pkg::EV_WORD;
        end else if (b >= 8'hc2 && b <= 8'hdf) begin
          pend_next = 2'd1;
          seql_next = 2'd1;
          cp_next   = {16'd0, b[4:0]};
        end else if (b >= 8'he0 && b <= 8'hef) begin
          pend_next = 2'd2;
          seql_next = 2'd2;
          cp_next   = {17'd0, b[3:0]};
        end else if (b >= 8'hf0 && b <= 8'hf4) begin
          pend_next = 2'd3;
          seql_next = 2'd3;
          cp_next   = {18'd0, b[2:0]};
        end else begin
          kind = ut_pkg::EV_UTF8;
        end
      end else if (b[7:6] != 2'b10) begin
        kind = ut_pkg::EV_UTF8;
      end else begin
        cp_next   = {cp[14:0], b[5:0]};
        pend_next = pend - 2'd1;
        if (pend_next == 2'd0) begin
          if (cp_next < minimum || cp_next > 21'h10ffff
              || (cp_next >= 21'hd800 && cp_next <= 21'hdfff)) begin
            kind = ut_pkg::EV_UTF8;
          end else begin
            kind = ut_pkg::is_space(cp_next) ? ut_pkg::EV_SPACE : ut_pkg::EV_WORD;
          end
        end
      end
      // truncated sequence at end of line
      if (kind != ut_pkg::EV_UTF8 && byte_ch.last_byte && pend_next != 2'd0) begin
        kind = ut_pkg::EV_UTF8;
      end
    end
  end

  always_comb begin
    ev.kind       = kind;
    ev.last       = byte_ch.last_byte;
    ev.char_start = cs_next;
    ev.byte_end   = pos_next;
  end

  // Decoder state, cleared at end of line
  always_ff @(posedge clk) begin
    if (rst || (acc && byte_ch.last_byte)) begin
      pend <= '0;
      seql <= '0;
      cp   <= '0;
      pos  <= '0;
      cs   <= '0;
    end else if (acc) begin
      pend <= pend_next;
      seql <= seql_next;
      cp   <= cp_next;
      pos  <= pos_next;
      cs   <= cs_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ut_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Short event queue between decoder and token tracker
module ut_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ut_pkg::ev_t  push_ev,
  input  wire logic         push_valid,
  output logic              push_ready,
  output ut_pkg::ev_t       pop_ev,
  output logic              pop_valid,
  input  wire logic         pop_ready
);

  localparam int CNT_QW = $clog2(ut_pkg::QDEPTH + 1);

  ut_pkg::ev_t               mem [ut_pkg::QDEPTH];
  logic [ut_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_QW-1:0]         count;
  logic                      push, pop;

  assign push_ready = count != CNT_QW'(ut_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_ev     = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [ut_pkg::QPTR_W-1:0] bump(input logic [ut_pkg::QPTR_W-1:0] p);
    bump = (p == ut_pkg::QPTR_W'(ut_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ev;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  overfill_a: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_QW'(ut_pkg::QDEPTH))
    else $error("event queue overfilled");

endmodule

`default_nettype wire

>>> rtl/core/ut_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Token tracker: runs, token limit, first error, result register
module ut_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ut_pkg::ev_t ev,
  input  wire logic        ev_valid,
  output logic             ev_ready,
  ut_tok_if.source         token_ch
);

  logic                       in_token, in_token_next;
  logic [ut_pkg::START_W-1:0] run_start, run_start_next;
  logic [ut_pkg::POS_W-1:0]   run_end, run_end_next;
  logic [ut_pkg::CNT_W-1:0]   tokens_seen, tokens_seen_next;
  ut_pkg::status_t            err, err_next;
  logic                       tok, emit, pop, had;

  assign ev_ready = !token_ch.valid || token_ch.ready;
  assign pop      = ev_valid && ev_ready;
  assign had      = err != ut_pkg::ST_OK;

  // Per-event run tracking
  always_comb begin
    in_token_next    = in_token;
    run_start_next   = run_start;
    run_end_next     = run_end;
    tokens_seen_next = tokens_seen;
    err_next         = err;
    tok              = 1'b0;
    if (!had) begin
      unique case (ev.kind)
        ut_pkg::EV_UTF8: begin
          err_next      = ut_pkg::ST_UTF8;
          in_token_next = 1'b0;
        end
        ut_pkg::EV_LONG: begin
          err_next      = ut_pkg::ST_LONG;
          in_token_next = 1'b0;
        end
        ut_pkg::EV_SPACE: begin
          tok = in_token;
        end
        ut_pkg::EV_WORD: begin
          if (!in_token) begin
            in_token_next  = 1'b1;
            run_start_next = ev.char_start;
          end
          run_end_next = ev.byte_end;
        end
        default: ;
      endcase
      if (err_next == ut_pkg::ST_OK && ev.last && in_token_next) tok = 1'b1;
      if (tok) begin
        in_token_next = 1'b0;
        if (tokens_seen >= ut_pkg::CNT_W'(ut_pkg::MAX_TOKENS)) begin
          err_next = ut_pkg::ST_TOKENS;
          tok      = 1'b0;
        end else begin
          tokens_seen_next = tokens_seen + 1'b1;
        end
      end
    end
    emit = tok || ev.last || (!had && err_next != ut_pkg::ST_OK);
  end

  // Line state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst || (pop && ev.last)) begin
      in_token    <= 1'b0;
      run_start   <= '0;
      run_end     <= '0;
      tokens_seen <= '0;
      err         <= ut_pkg::ST_OK;
    end else if (pop) begin
      in_token    <= in_token_next;
      run_start   <= run_start_next;
      run_end     <= run_end_next;
      tokens_seen <= tokens_seen_next;
      err         <= err_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_ch.valid <= 1'b0;
    end else if (ev_ready) begin
      token_ch.valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      token_ch.has_token    <= tok;
      token_ch.token_start  <= tok ? run_start_next : '0;
      token_ch.token_length <= tok ? ut_pkg::LEN_W'(run_end_next
                                       - ut_pkg::POS_W'(run_start_next)) : '0;
      token_ch.token_number <= tok ? tokens_seen[ut_pkg::NUM_W-1:0] : '0;
      token_ch.status       <= err_next;
      token_ch.end_of_line  <= ev.last;
    end
  end

  tok_ok_a: assert property (@(posedge clk) disable iff (rst)
    token_ch.valid && token_ch.has_token |-> token_ch.status == ut_pkg::ST_OK)
    else $error("token given with error status");

  no_tok_zero_a: assert property (@(posedge clk) disable iff (rst)
    token_ch.valid && !token_ch.has_token |->
      token_ch.token_length == '0 && token_ch.token_start == '0
      && token_ch.token_number == '0)
    else $error("non-token result carries token fields");

  limit_a: assert property (@(posedge clk) disable iff (rst)
    tokens_seen <= ut_pkg::CNT_W'(ut_pkg::MAX_TOKENS))
    else $error("token count past limit");

  eol_clear_a: assert property (@(posedge clk) disable iff (rst)
    pop && ev.last |=> tokens_seen == '0 && !in_token && err == ut_pkg::ST_OK)
    else $error("line state not cleared after final byte");

endmodule

`default_nettype wire
